@@ src/qisc_pkg.sv @@
// Shared constants for the quad/ij to sequence number converter.
// Used by quad_ij_seqnum_convert and its port checker; no dependencies.
package qisc_pkg;

  // Configuration register indexes
  parameter int CFG_IDX_W = 2;
  parameter logic [CFG_IDX_W-1:0] CFG_GRID_DIM = 2'd0;
  parameter logic [CFG_IDX_W-1:0] CFG_CELLS    = 2'd1;
  parameter logic [CFG_IDX_W-1:0] CFG_OFFSET   = 2'd2;

  // Direction codes carried in tuser
  parameter logic KIND_FWD = 1'b0;
  parameter logic KIND_INV = 1'b1;

  // Register and datapath widths fixed by the cell addressing
  parameter int DIM_W    = 32;  // grid_dim
  parameter int CPQ_W    = 60;  // cells_per_quad
  parameter int MULT_W   = 64;  // exact multiples of cells_per_quad
  parameter int DVD_W    = 62;  // dividend of the row/column division
  parameter int QUAD_W   = 4;
  parameter int NUM_MULT = 15;  // multiples 0..14 of cells_per_quad

  parameter logic [QUAD_W-1:0] LAST_QUAD = 4'd11;

  // x / 3 == (x * RECIP3) >> RECIP3_SHIFT for any 32-bit x
  parameter logic [31:0] RECIP3       = 32'hAAAA_AAAB;
  parameter int          RECIP3_SHIFT = 33;

endpackage

@@ src/quad_ij_seqnum_convert.sv @@
// Top level: pipelined quad/ij <-> sequence number converter.
// Depends on qisc_pkg; port checker bound from qisc_chk.sv.
//
//  channel | dir | tdata (low bit up)                       | tuser
//  --------+-----+------------------------------------------+--------------
//  in_     | in  | quad_in, row_in, col_in, seq_in          | kind
//  out_    | out | seq_out, quad_out, row_out, col_out      | out_of_range
//  cfg_    | in  | cfg_we, cfg_addr, cfg_wdata (no read)    | -
//
// One beat per cycle sustained while out_tready stays high; four front stages
// (reciprocal multiply, quad compare/offset, main multiply/subtract, final add)
// then a 62-stage restoring divider by grid_dim, one quotient bit per stage.
// rst_n clears all valid bits and restores the register defaults.
// Each stage holds its beat only while the next one is full and stalled, so
// empty stages keep filling while out_tready is low.
module quad_ij_seqnum_convert #(
  parameter int COORD_BITS = 32,
  parameter int SEQ_BITS   = 62
) (
  input  logic clk,
  input  logic rst_n,
  // quad_in, row_in, col_in, seq_in
  input  logic [((4+2*COORD_BITS+SEQ_BITS+7)/8)*8-1:0] in_tdata,
  input  logic in_tuser,  // kind
  input  logic in_tvalid,
  output logic in_tready,
  // seq_out, quad_out, row_out, col_out
  output logic [((4+2*COORD_BITS+SEQ_BITS+7)/8)*8-1:0] out_tdata,
  output logic out_tuser,  // out_of_range
  output logic out_tvalid,
  input  logic out_tready,
  input  logic cfg_we,
  input  logic [qisc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [qisc_pkg::CPQ_W-1:0] cfg_wdata
);

  localparam int CW    = COORD_BITS;
  localparam int SW    = SEQ_BITS;
  localparam int QW    = qisc_pkg::QUAD_W;
  localparam int DW    = qisc_pkg::DVD_W;
  localparam int MW    = qisc_pkg::MULT_W;
  localparam int GW    = qisc_pkg::DIM_W;
  localparam int OUT_W = ((4+2*CW+SW+7)/8)*8;

  typedef struct packed {
    logic          kind;
    logic [QW-1:0] quad;
    logic [CW-1:0] i;
    logic [CW-1:0] j;
    logic [CW-1:0] a;   // i / 3
    logic [CW-1:0] qj;  // j / 3
    logic [SW-1:0] r;   // seq - 2
    logic          zero;
    logic          one;
  } s1_t;

  typedef struct packed {
    logic          kind;
    logic          zero;
    logic          one;
    logic [SW-1:0] r;
    logic [10:0]   ge;     // r >= k * cells_per_quad, k = 1..11
    logic [CW-1:0] mop;    // multiplier operand
    logic [CW-1:0] jterm;
    logic [GW-1:0] ext;    // floor((i mod 3) * grid_dim / 3)
    logic [SW-1:0] offm;   // quad offset
  } s2_t;

  typedef struct packed {
    logic                       kind;
    logic                       zero;
    logic                       one;
    logic                       over;
    logic [QW-1:0]              quad;
    logic [qisc_pkg::CPQ_W-1:0] rem;
    logic [SW-1:0]              m;
    logic [SW-1:0]              part;
  } s3_t;

  typedef struct packed {
    logic          kind;
    logic          flag;
    logic          kill;  // inverse fields forced to zero
    logic [QW-1:0] quad;
    logic [SW-1:0] seq;
    logic [DW-1:0] dvd;
    logic [GW-1:0] prem;
    logic [CW-1:0] qlow;
    logic [1:0]    qm3;   // full quotient mod 3
  } div_t;

  typedef struct packed {
    logic [SW-1:0] seq;
    logic [QW-1:0] quad;
    logic [CW-1:0] row;
    logic [CW-1:0] col;
    logic          flag;
  } res_t;

  // quotient mod 3 after appending one bit
  function automatic logic [1:0] mod3_step(input logic [1:0] m, input logic b);
    logic [1:0] res;
    unique case (m)
      2'd0:    res = b ? 2'd1 : 2'd0;
      2'd1:    res = b ? 2'd0 : 2'd2;
      2'd2:    res = b ? 2'd2 : 2'd1;
      default: res = 2'd0;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers and derived constants
  // ---------------------------------------------------------------------
  logic [GW-1:0] gd_r;
  logic [GW-2:0] gd3_r;
  logic [1:0]    gdm3_r;
  logic          off_r;
  logic [MW-1:0] mult_r [qisc_pkg::NUM_MULT];

  logic [63:0]   gd_prod;
  logic [GW-2:0] gd3_nxt;
  logic [1:0]    gdm3_nxt;

  always_comb begin
    gd_prod  = 64'(cfg_wdata[GW-1:0]) * 64'(qisc_pkg::RECIP3);
    gd3_nxt  = gd_prod[63:qisc_pkg::RECIP3_SHIFT];
    gdm3_nxt = 2'(cfg_wdata[GW-1:0] - 32'(gd3_nxt) * 32'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gd_r   <= GW'(1);
      gd3_r  <= '0;
      gdm3_r <= 2'd1;
      off_r  <= 1'b0;
      for (int k = 0; k < qisc_pkg::NUM_MULT; k++) begin
        mult_r[k] <= MW'(k);
      end
    end else if (cfg_we) begin
      unique case (cfg_addr)
        qisc_pkg::CFG_GRID_DIM: begin
          gd_r   <= cfg_wdata[GW-1:0];
          gd3_r  <= gd3_nxt;
          gdm3_r <= gdm3_nxt;
        end
        qisc_pkg::CFG_CELLS: begin
          for (int k = 0; k < qisc_pkg::NUM_MULT; k++) begin
            mult_r[k] <= MW'(k) * MW'(cfg_wdata);
          end
        end
        qisc_pkg::CFG_OFFSET: off_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage valids and per-stage load enables
  // ---------------------------------------------------------------------
  logic          v1_r, v2_r, v3_r, v4_r, ov_r;
  logic [DW-1:0] dv_r;
  logic          ld1, ld2, ld3, ld4, ldo;
  logic [DW-1:0] dld;

  assign ldo = !ov_r || out_tready;
  assign ld4 = !v4_r || dld[0];
  assign ld3 = !v3_r || ld4;
  assign ld2 = !v2_r || ld3;
  assign ld1 = !v1_r || ld2;
  assign in_tready = ld1;

  // ---------------------------------------------------------------------
  // Stage 1: divide i and j by three, form seq - 2
  // ---------------------------------------------------------------------
  s1_t s1_nxt, s1_r;
  logic [CW-1:0] in_row, in_col;
  logic [SW-1:0] in_seq;
  logic [63:0]   pi, pj;

  always_comb begin
    in_row = in_tdata[QW +: CW];
    in_col = in_tdata[QW+CW +: CW];
    in_seq = in_tdata[QW+2*CW +: SW];
    pi = 64'(in_row) * 64'(qisc_pkg::RECIP3);
    pj = 64'(in_col) * 64'(qisc_pkg::RECIP3);
    s1_nxt.kind = in_tuser;
    s1_nxt.quad = in_tdata[QW-1:0];
    s1_nxt.i    = in_row;
    s1_nxt.j    = in_col;
    s1_nxt.a    = CW'(pi[63:qisc_pkg::RECIP3_SHIFT]);
    s1_nxt.qj   = CW'(pj[63:qisc_pkg::RECIP3_SHIFT]);
    s1_nxt.r    = in_seq - SW'(2);
    s1_nxt.zero = (in_seq == '0);
    s1_nxt.one  = (in_seq == SW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ld1) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1 && in_tvalid) begin
      s1_r <= s1_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: column term, quad offset, quad search compares
  // ---------------------------------------------------------------------
  s2_t s2_nxt, s2_r;
  logic [1:0]    b, rj, cp;
  logic [CW-1:0] jt;
  logic [QW-1:0] qm1;
  logic [63:0]   offm_full;

  always_comb begin
    b   = 2'(s1_r.i - (s1_r.a + (s1_r.a << 1)));
    rj  = 2'(s1_r.j - (s1_r.qj + (s1_r.qj << 1)));
    unique case (b)
      2'd1:    cp = 2'd2;
      2'd2:    cp = 2'd1;
      default: cp = 2'd0;
    endcase
    // truncate a negative column numerator to zero
    if (cp == 2'd0 || rj >= cp) begin
      jt = s1_r.qj;
    end else if (s1_r.qj == '0) begin
      jt = '0;
    end else begin
      jt = s1_r.qj - CW'(1);
    end
    qm1       = s1_r.quad - QW'(1);
    offm_full = 64'(qm1) * 64'(mult_r[1][qisc_pkg::CPQ_W-1:0]) + 64'd1;

    s2_nxt.kind  = s1_r.kind;
    s2_nxt.zero  = s1_r.zero;
    s2_nxt.one   = s1_r.one;
    s2_nxt.r     = s1_r.r;
    for (int k = 0; k < 11; k++) begin
      s2_nxt.ge[k] = (MW'(s1_r.r) >= mult_r[k+1]);
    end
    s2_nxt.mop   = off_r ? s1_r.a : s1_r.i;
    s2_nxt.jterm = off_r ? jt : s1_r.j;
    if (!off_r || b == 2'd0) begin
      s2_nxt.ext = '0;
    end else if (b == 2'd1) begin
      s2_nxt.ext = GW'(gd3_r);
    end else begin
      s2_nxt.ext = {gd3_r, 1'b0} + GW'(gdm3_r == 2'd2);
    end
    s2_nxt.offm  = (s1_r.quad == '0) ? '0 : SW'(offm_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (ld2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2 && v1_r) begin
      s2_r <= s2_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: row multiply, partial sum, remainder inside the quad
  // ---------------------------------------------------------------------
  s3_t s3_nxt, s3_r;
  logic [QW-1:0] qq;
  logic [MW-1:0] m_full, rem_full;

  always_comb begin
    qq       = QW'($countones(s2_r.ge[9:0]));
    m_full   = MW'(s2_r.mop) * MW'(gd_r);
    rem_full = MW'(s2_r.r) - mult_r[qq];
    s3_nxt.kind = s2_r.kind;
    s3_nxt.zero = s2_r.zero;
    s3_nxt.one  = s2_r.one;
    s3_nxt.over = s2_r.ge[10];
    s3_nxt.quad = qq + QW'(1);
    s3_nxt.rem  = rem_full[qisc_pkg::CPQ_W-1:0];
    s3_nxt.m    = SW'(m_full);
    s3_nxt.part = s2_r.offm + SW'(s2_r.jterm) + SW'(s2_r.ext) + SW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (ld3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld3 && v2_r) begin
      s3_r <= s3_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: final forward add, divider load
  // ---------------------------------------------------------------------
  div_t s4_nxt, s4_r;
  logic gd_zero;

  always_comb begin
    gd_zero = (gd_r == '0);
    s4_nxt.kind = s3_r.kind;
    s4_nxt.flag = s3_r.zero || (!s3_r.one && (s3_r.over || gd_zero));
    s4_nxt.kill = s3_r.zero || s3_r.one || s3_r.over || gd_zero;
    s4_nxt.quad = s3_r.quad;
    s4_nxt.seq  = s3_r.m + s3_r.part;
    s4_nxt.dvd  = off_r ? (DW'(s3_r.rem) << 1) + DW'(s3_r.rem) : DW'(s3_r.rem);
    s4_nxt.prem = '0;
    s4_nxt.qlow = '0;
    s4_nxt.qm3  = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (ld4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld4 && v3_r) begin
      s4_r <= s4_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Restoring divider by grid_dim, one quotient bit per stage
  // ---------------------------------------------------------------------
  div_t dd_r   [DW];
  div_t dd_nxt [DW];

  for (genvar k = 0; k < DW; k++) begin : g_div
    div_t        dp;
    logic        dp_v;
    logic        qb;
    logic [GW:0] t;

    if (k == 0) begin : g_first
      assign dp   = s4_r;
      assign dp_v = v4_r;
    end else begin : g_next
      assign dp   = dd_r[k-1];
      assign dp_v = dv_r[k-1];
    end

    if (k == DW-1) begin : g_last_ld
      assign dld[k] = !dv_r[k] || ldo;
    end else begin : g_mid_ld
      assign dld[k] = !dv_r[k] || dld[k+1];
    end

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
      t  = {dp.prem, dp.dvd[DW-1-k]};
      qb = (t >= {1'b0, gd_r});
      dd_nxt[k]      = dp;
      dd_nxt[k].prem = qb ? GW'(t - {1'b0, gd_r}) : t[GW-1:0];
      dd_nxt[k].qlow = {dp.qlow[CW-2:0], qb};
      dd_nxt[k].qm3  = mod3_step(dp.qm3, qb);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else if (dld[k]) begin
        dv_r[k] <= dp_v;
      end
    end

    always_ff @(posedge clk) begin
      if (dld[k] && dp_v) begin
        dd_r[k] <= dd_nxt[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register: offset-grid column fix-up, zero the unused fields
  // ---------------------------------------------------------------------
  res_t   o_nxt, o_r;
  div_t   dl;
  logic [1:0]  adj;
  logic [GW:0] col_full;

  always_comb begin
    dl = dd_r[DW-1];
    if (!off_r) begin
      adj = 2'd0;
    end else if (dl.qm3 == 2'd1) begin
      adj = 2'd2;
    end else if (dl.qm3 == 2'd2) begin
      adj = 2'd1;
    end else begin
      adj = 2'd0;
    end
    col_full = {1'b0, dl.prem} + (GW+1)'(adj);
    o_nxt = '0;
    if (dl.kind == qisc_pkg::KIND_FWD) begin
      o_nxt.seq = dl.seq;
    end else if (dl.kill) begin
      o_nxt.flag = dl.flag;
    end else begin
      o_nxt.quad = dl.quad;
      o_nxt.row  = dl.qlow;
      o_nxt.col  = CW'(col_full);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (ldo) begin
      ov_r <= dv_r[DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ldo && dv_r[DW-1]) begin
      o_r <= o_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = o_r.flag;
  assign out_tdata  = OUT_W'({o_r.col, o_r.row, o_r.quad, o_r.seq});

endmodule

@@ src/qisc_chk.sv @@
// Port-level checker for quad_ij_seqnum_convert, attached by bind below.
// Depends on qisc_pkg for the quad field width and limit.
module qisc_chk #(
  parameter int COORD_BITS = 32,
  parameter int SEQ_BITS   = 62
) (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic [((4+2*COORD_BITS+SEQ_BITS+7)/8)*8-1:0] out_tdata,
  input logic out_tuser,
  input logic out_tvalid,
  input logic out_tready
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

  // flagged result carries all-zero fields
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("out_of_range beat with nonzero fields");

  // quad never exceeds the last quad
  a_quad_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[SEQ_BITS +: qisc_pkg::QUAD_W] <= qisc_pkg::LAST_QUAD)
    else $error("quad_out above last quad");

  // empty output stage lets the whole pipe load
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output stage");

  // reset drops the output valid
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid after reset");

endmodule

bind quad_ij_seqnum_convert qisc_chk #(
  .COORD_BITS(COORD_BITS),
  .SEQ_BITS(SEQ_BITS)
) u_qisc_chk (.*);

@@ tb/tb_quad_ij_seqnum_convert.sv @@
// Self-checking testbench for quad_ij_seqnum_convert: directed table, then random phases.
// Predicts each untyped result in SystemVerilog and checks every beat; depends on qisc_pkg and the DUT.
module tb_quad_ij_seqnum_convert;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W    = 136;
  localparam int LATENCY   = 67;
  localparam int LIMIT     = 400000;
  localparam int HOLD_LEN  = 300;
  localparam int N_PHASES  = 8;
  localparam int PHASE_LEN = 195;
  localparam logic FWD = qisc_pkg::KIND_FWD;
  localparam logic INV = qisc_pkg::KIND_INV;

  typedef struct packed {
    logic        kind;
    logic [3:0]  quad;
    logic [31:0] row;
    logic [31:0] col;
    logic [61:0] seq;
  } cell_req_t;

  typedef struct packed {
    logic [61:0] seq;
    logic [3:0]  quad;
    logic [31:0] row;
    logic [31:0] col;
    logic        oor;
  } cell_res_t;

  typedef struct packed {
    cell_req_t req;
    logic      typed;
    cell_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [qisc_pkg::CFG_IDX_W-1:0] cfg_addr = qisc_pkg::CFG_GRID_DIM;
  logic [qisc_pkg::CPQ_W-1:0] cfg_wdata = '0;

  // Shadow copy of the configuration, kept at the write edge
  logic [31:0] grid_dim_q = 32'd1;
  logic [59:0] cells_q = 60'd1;
  logic offset_q = 1'b0;

  cell_res_t cell_results_q[$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int checked = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  quad_ij_seqnum_convert dut (.*);

  always #5 clk = ~clk;

  // Track register writes
  always @(posedge clk) begin
    if (rst_n && cfg_we) begin
      case (cfg_addr)
        qisc_pkg::CFG_GRID_DIM: grid_dim_q <= cfg_wdata[31:0];
        qisc_pkg::CFG_CELLS:    cells_q <= cfg_wdata;
        qisc_pkg::CFG_OFFSET:   offset_q <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Expected conversion for one request under the current registers
  function automatic cell_res_t convert_cell(cell_req_t r);
    cell_res_t o;
    logic [63:0] gd, cpq, i, j, off, base, idx, s, rr, qq, rem, ii, jj;
    o = '0;
    gd = {32'd0, grid_dim_q};
    cpq = {4'd0, cells_q};
    if (r.kind == FWD) begin
      i = {32'd0, r.row};
      j = {32'd0, r.col};
      off = (r.quad == 4'd0) ? 64'd0 : 64'd1 + ({60'd0, r.quad} - 64'd1) * cpq;
      if (!offset_q) begin
        idx = i * gd + j;
      end else begin
        base = (i * gd) / 3;
        case (i % 3)
          64'd0: idx = base + j / 3;
          64'd1: idx = base + ((j >= 2) ? (j - 2) / 3 : 64'd0);
          default: idx = base + ((j >= 1) ? (j - 1) / 3 : 64'd0);
        endcase
      end
      s = off + idx + 64'd1;
      o.seq = s[61:0];
    end else begin
      s = {2'd0, r.seq};
      if (s == 64'd0) begin
        o.oor = 1'b1;
      end else if (s >= 64'd2) begin
        rr = s - 64'd2;
        if (cpq == 64'd0 || gd == 64'd0) begin
          o.oor = 1'b1;
        end else begin
          qq = rr / cpq;
          if (qq > 64'd10) begin
            o.oor = 1'b1;
          end else begin
            rem = rr % cpq;
            o.quad = qq[3:0] + 4'd1;
            if (offset_q) begin
              ii = (rem * 3) / gd;
              jj = (rem * 3) % gd;
              if (ii % 3 == 64'd1) jj = jj + 2;
              else if (ii % 3 == 64'd2) jj = jj + 1;
            end else begin
              ii = rem / gd;
              jj = rem % gd;
            end
            o.row = ii[31:0];
            o.col = jj[31:0];
          end
        end
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH beat %0d %s: got %0h want %0h", checked, field, got, want);
    errors++;
  endtask

  // Drive the cfg port for one cycle
  task automatic write_reg(logic [qisc_pkg::CFG_IDX_W-1:0] idx,
                           logic [qisc_pkg::CPQ_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one beat with random gaps and hold it until taken
  task automatic send_cell(cell_req_t r, logic typed, cell_res_t typed_res);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= r.kind;
    in_tdata <= {6'd0, r.seq, r.col, r.row, r.quad};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    cell_results_q.push_back(typed ? typed_res : convert_cell(r));
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (cell_results_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random request, mostly well-formed for the current grid
  function automatic cell_req_t random_cell();
    cell_req_t r;
    logic [63:0] top;
    r.kind = 1'($urandom_range(0, 1));
    r.quad = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 11))
                                          : 4'($urandom_range(12, 15));
    if (grid_dim_q != 0 && $urandom_range(0, 99) < 80) begin
      r.row = $urandom % grid_dim_q;
      r.col = $urandom % grid_dim_q;
      // keep (i+j) divisible by three in the offset grid most of the time
      if (offset_q && $urandom_range(0, 99) < 80 && r.col >= 2)
        r.col = r.col - ((r.row + r.col) % 3);
    end else begin
      r.row = $urandom;
      r.col = $urandom;
    end
    top = 64'd11 * {4'd0, cells_q} + 64'd6;
    if ($urandom_range(0, 99) < 80) r.seq = 62'(rand64() % top);
    else r.seq = 62'(rand64());
    return r;
  endfunction

  // Receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compare each result beat with the oldest expected conversion
  always @(posedge clk) begin
    cell_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (cell_results_q.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata[63:0], 64'd0);
      end else begin
        want = cell_results_q.pop_front();
        if (out_tdata[61:0] != want.seq)
          report_mismatch("seq", 64'(out_tdata[61:0]), 64'(want.seq));
        if (out_tdata[65:62] != want.quad)
          report_mismatch("quad", 64'(out_tdata[65:62]), 64'(want.quad));
        if (out_tdata[97:66] != want.row)
          report_mismatch("row", 64'(out_tdata[97:66]), 64'(want.row));
        if (out_tdata[129:98] != want.col)
          report_mismatch("col", 64'(out_tdata[129:98]), 64'(want.col));
        if (out_tuser != want.oor)
          report_mismatch("out_of_range", 64'(out_tuser), 64'(want.oor));
      end
      checked++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Directed rows under reset registers; typed rows carry their result
  dir_row_t dir_rows[] = '{
    '{'{FWD, 4'd0, 32'd0, 32'd0, 62'd0}, 1'b1, '{62'd1, 4'd0, 32'd0, 32'd0, 1'b0}},
    '{'{FWD, 4'd11, 32'd0, 32'd0, 62'd0}, 1'b1, '{62'd12, 4'd0, 32'd0, 32'd0, 1'b0}},
    '{'{FWD, 4'd15, '1, '1, 62'd0}, 1'b1,
      '{62'h2_0000_000E, 4'd0, 32'd0, 32'd0, 1'b0}},
    '{'{FWD, 4'd12, '1, 32'd0, '1}, 1'b0, '0},
    '{'{FWD, 4'd1, 32'd0, '1, 62'd5}, 1'b0, '0},
    '{'{INV, 4'd0, 32'd0, 32'd0, 62'd0}, 1'b1, '{62'd0, 4'd0, 32'd0, 32'd0, 1'b1}},
    '{'{INV, 4'd0, 32'd0, 32'd0, 62'd1}, 1'b1, '{62'd0, 4'd0, 32'd0, 32'd0, 1'b0}},
    '{'{INV, 4'd0, 32'd0, 32'd0, 62'd2}, 1'b1, '{62'd0, 4'd1, 32'd0, 32'd0, 1'b0}},
    '{'{INV, 4'd0, 32'd0, 32'd0, 62'd12}, 1'b1, '{62'd0, 4'd11, 32'd0, 32'd0, 1'b0}},
    '{'{INV, 4'd0, 32'd0, 32'd0, 62'd13}, 1'b1, '{62'd0, 4'd0, 32'd0, 32'd0, 1'b1}},
    '{'{INV, '1, '1, '1, '1}, 1'b1, '{62'd0, 4'd0, 32'd0, 32'd0, 1'b1}},
    '{'{INV, 4'd0, 32'd0, 32'd0, 62'd7}, 1'b0, '0}
  };

  // Register settings per random phase: grid_dim, cells_per_quad, offset_grid
  logic [31:0] ph_dim[N_PHASES] = '{32'd10, 32'd9, '1, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0};
  logic [59:0] ph_cells[N_PHASES] = '{60'd100, 60'd27, '1, 60'd0, 60'd1, 60'd0, 60'd0, 60'd0};
  logic ph_off[N_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

  initial begin
    int d;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[k]) send_cell(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].res);

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      // later phases take random small grids
      if (p >= 5) begin
        d = $urandom_range(1, 200);
        ph_dim[p] = 32'(d);
        ph_off[p] = 1'($urandom_range(0, 1));
        ph_cells[p] = ph_off[p] ? 60'((d * d) / 3 + 1) : 60'(d * d);
      end
      write_reg(qisc_pkg::CFG_GRID_DIM, {28'd0, ph_dim[p]});
      write_reg(qisc_pkg::CFG_CELLS, ph_cells[p]);
      write_reg(qisc_pkg::CFG_OFFSET, {59'd0, ph_off[p]});
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      if (p == 0) hold_req = 1'b1;
      for (int n = 0; n < PHASE_LEN; n++) send_cell(random_cell(), 1'b0, '0);
    end
    drain();

    $display("Covered %0d requests over %0d register settings plus reset defaults;",
             sent, N_PHASES);
    $display("%0d result beats checked in %0d cycles", checked, cycles);
    if (errors == 0 && cell_results_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, cell_results_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
